>>> src/request_script_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef REQUEST_SCRIPT_TOKENIZER_TOP_DEFINES_SVH
`define REQUEST_SCRIPT_TOKENIZER_TOP_DEFINES_SVH

// Checked only while out of reset
`define RST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define CLK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/reqtok_pkg.sv
// Types, keyword tables and character classes for the request script tokenizer.
// No dependencies.
package reqtok_pkg;

  localparam int unsigned PosBitsDefault = 16;
  localparam int unsigned NumKw          = 11;
  localparam int unsigned MaxRes         = 3;
  localparam int unsigned FifoDepth      = 4;
  localparam int unsigned FifoAw         = $clog2(FifoDepth);
  localparam int unsigned FifoCw         = $clog2(FifoDepth + 1);

  typedef enum logic [4:0] {
    KIND_EOF      = 5'd0,
    KIND_ERROR    = 5'd1,
    KIND_NEWLINE  = 5'd2,
    KIND_GET      = 5'd3,
    KIND_POST     = 5'd4,
    KIND_PUT      = 5'd5,
    KIND_DELETE   = 5'd6,
    KIND_PATCH    = 5'd7,
    KIND_EXPECT   = 5'd8,
    KIND_STATUS   = 5'd9,
    KIND_HEADER   = 5'd10,
    KIND_BODYKW   = 5'd11,
    KIND_CONTAINS = 5'd12,
    KIND_BODYSTMT = 5'd13,
    KIND_INT      = 5'd14,
    KIND_STRING   = 5'd15,
    KIND_IDENT    = 5'd16,
    KIND_RAWBODY  = 5'd17
  } tok_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNTERM   = 2'd1,
    ERR_BAD_CHAR = 2'd2
  } err_code_e;

  // Scanner modes, one-hot
  typedef enum logic [7:0] {
    M_IDLE      = 8'b0000_0001,
    M_INT       = 8'b0000_0010,
    M_IDENT     = 8'b0000_0100,
    M_STRING    = 8'b0000_1000,
    M_COMMENT   = 8'b0001_0000,
    M_BODY_WAIT = 8'b0010_0000,
    M_BODY      = 8'b0100_0000,
    M_DONE      = 8'b1000_0000
  } mode_e;

  // One token; packed so that the first tdata field is lowest
  typedef struct packed {
    logic            last;
    tok_kind_e       kind;
    logic [15:0]     col;
    logic [15:0]     line;
    logic [15:0]     len;
    logic [15:0]     off;
    logic [7:0]      ch;
    err_code_e       err;
  } tok_t;

  localparam logic [3:0] KwLen [NumKw] = '{
    4'd3, 4'd4, 4'd3, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd4, 4'd8, 4'd4
  };

  localparam logic [7:0] KwTab [NumKw][8] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
    '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00},
    '{"E", "X", "P", "E", "C", "T", 8'h00, 8'h00},
    '{"s", "t", "a", "t", "u", "s", 8'h00, 8'h00},
    '{"h", "e", "a", "d", "e", "r", 8'h00, 8'h00},
    '{"b", "o", "d", "y", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"c", "o", "n", "t", "a", "i", "n", "s"},
    '{"B", "O", "D", "Y", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return is_alpha(c) || c == "_" || c == "-" || c == ":" || c == "/" || c == ".";
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_word_start(c) || is_digit(c) || c == "?" || c == "&" ||
           c == "=" || c == "%" || c == "#";
  endfunction

  // Drop every keyword that cannot take byte c at position wl
  function automatic logic [NumKw-1:0] kw_match(input logic [NumKw-1:0] flags,
                                                input logic [3:0] wl,
                                                input logic [7:0] c);
    logic [NumKw-1:0] f;
    f = flags;
    for (int k = 0; k < NumKw; k++) begin
      if (wl >= KwLen[k] || KwTab[k][wl[2:0]] != c) f[k] = 1'b0;
    end
    return f;
  endfunction

  // Lowest matching keyword wins, else plain identifier
  function automatic tok_kind_e kw_kind(input logic [NumKw-1:0] flags,
                                        input logic [3:0] wl);
    tok_kind_e kd;
    kd = KIND_IDENT;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (flags[k] && wl == KwLen[k]) kd = tok_kind_e'(5'(int'(KIND_GET) + k));
    end
    return kd;
  endfunction

  function automatic tok_t mk_tok(input tok_kind_e kind, input err_code_e err,
                                  input logic [7:0] ch, input logic [15:0] off,
                                  input logic [15:0] len, input logic [15:0] line,
                                  input logic [15:0] col, input logic last);
    tok_t t;
    t.last = last;
    t.kind = kind;
    t.col  = col;
    t.line = line;
    t.len  = len;
    t.off  = off;
    t.ch   = ch;
    t.err  = err;
    return t;
  endfunction

endpackage

>>> src/request_script_tokenizer_top.sv
// Request script tokenizer: input register, one-pass scanner, token queue.
// Depends on reqtok_pkg and request_script_tokenizer_top_defines.svh.
// A token's ending byte is held in the input register; the scanner then writes the token into the queue.
// Throughput: one byte per cycle while the 4-entry token queue can take the three tokens
// one byte may cause; output stalls slow input. After EOF or ERROR bytes are dropped.
// Reset (rst_ni low, async): empty queue, scanner idle at offset 0, line 1, col 1.
`include "request_script_tokenizer_top_defines.svh"

module request_script_tokenizer_top #(
  parameter int unsigned POSITION_BITS = reqtok_pkg::PosBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // error_code, error_char, text_offset,
                                        // text_length, start_line, start_column, pad
  output logic [4:0]  m_axis_tuser_o,   // token_kind
  output logic        m_axis_tlast_o    // last
);
  import reqtok_pkg::*;

  localparam int unsigned Pb = POSITION_BITS;

  // Input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       eot_q;

  // Scanner state
  mode_e            mode_q, mode_d;
  logic [Pb-1:0]    off_q, off_d, line_q, line_d, col_q, col_d;
  logic [Pb-1:0]    ts_off_q, ts_off_d, ts_line_q, ts_line_d, ts_col_q, ts_col_d;
  logic [Pb-1:0]    tbl_q, tbl_d;
  logic [NumKw-1:0] flags_q, flags_d;
  logic [3:0]       wl_q, wl_d;

  // Token queue
  tok_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCw-1:0] cnt_q;

  tok_t       res [MaxRes];
  logic [1:0] n_res;
  logic       proc, pop, room;

  function automatic logic [Pb-1:0] sat_inc(input logic [Pb-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [Pb-1:0] span(input logic [Pb-1:0] a, input logic [Pb-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Handshake: room for a worst-case byte after this cycle's pop
  assign pop             = (cnt_q != '0) && m_axis_tready_i;
  assign room            = cnt_q <= FifoCw'(FifoDepth - MaxRes) + FifoCw'(pop);
  assign proc            = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o) begin
      byte_q <= s_axis_tdata_i;
      eot_q  <= s_axis_tlast_i;
    end
  end

  // Scanner: current mode, then body-wait and idle handling of the same byte
  always_comb begin
    logic      eot, blank, cr, nl, cont;
    logic [7:0] c;
    tok_kind_e wk;
    c       = byte_q;
    eot     = eot_q || (c == 8'h00);
    blank   = (c == " ") || (c == 8'h09);
    cr      = (c == 8'h0d);
    nl      = (c == 8'h0a);
    cont    = 1'b0;
    wk      = KIND_IDENT;
    mode_d  = mode_q;
    off_d   = off_q;
    line_d  = line_q;
    col_d   = col_q;
    ts_off_d  = ts_off_q;
    ts_line_d = ts_line_q;
    ts_col_d  = ts_col_q;
    tbl_d   = tbl_q;
    flags_d = flags_q;
    wl_d    = wl_q;
    n_res   = 2'd0;
    for (int i = 0; i < MaxRes; i++) res[i] = '0;

    if (proc) begin
      case (mode_q)
        M_IDLE, M_BODY_WAIT: cont = 1'b1;
        M_INT: begin
          if (eot || !is_digit(c)) begin
            res[n_res] = mk_tok(KIND_INT, ERR_NONE, 8'h00, 16'(ts_off_q),
                                16'(span(off_q, ts_off_q)), 16'(ts_line_q),
                                16'(ts_col_q), 1'b0);
            n_res  = n_res + 2'd1;
            mode_d = M_IDLE;
            cont   = 1'b1;
          end
        end
        M_IDENT: begin
          if (!eot && is_word_char(c)) begin
            flags_d = kw_match(flags_q, wl_q, c);
            wl_d    = (wl_q == 4'hf) ? wl_q : wl_q + 4'd1;
          end else begin
            wk = kw_kind(flags_q, wl_q);
            res[n_res] = mk_tok(wk, ERR_NONE, 8'h00, 16'(ts_off_q),
                                16'(span(off_q, ts_off_q)), 16'(ts_line_q),
                                16'(ts_col_q), 1'b0);
            n_res  = n_res + 2'd1;
            mode_d = (wk == KIND_BODYSTMT) ? M_BODY_WAIT : M_IDLE;
            cont   = 1'b1;
          end
        end
        M_STRING: begin
          if (eot || nl) begin
            res[n_res] = mk_tok(KIND_ERROR, ERR_UNTERM, 8'h00, 16'(ts_off_q), 16'd0,
                                16'(ts_line_q), 16'(ts_col_q), 1'b1);
            n_res  = n_res + 2'd1;
            mode_d = M_DONE;
          end else if (c == "\"") begin
            res[n_res] = mk_tok(KIND_STRING, ERR_NONE, 8'h00, 16'(sat_inc(ts_off_q)),
                                16'(span(off_q, sat_inc(ts_off_q))), 16'(ts_line_q),
                                16'(ts_col_q), 1'b0);
            n_res  = n_res + 2'd1;
            mode_d = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (eot || nl) begin
            mode_d = M_IDLE;
            cont   = 1'b1;
          end
        end
        M_BODY: begin
          if (eot || nl || cr) begin
            res[n_res] = mk_tok(KIND_RAWBODY, ERR_NONE, 8'h00, 16'(ts_off_q),
                                16'(tbl_q), 16'(ts_line_q), 16'(ts_col_q), 1'b0);
            n_res  = n_res + 2'd1;
            mode_d = M_IDLE;
            cont   = 1'b1;
          end else if (!blank) begin
            tbl_d = sat_inc(span(off_q, ts_off_q));
          end
        end
        M_DONE: cont = 1'b0;
        default: mode_d = M_DONE;
      endcase

      // After BODY keyword: skip blanks, then empty body or body start
      if (cont && mode_d == M_BODY_WAIT) begin
        if (!eot && (blank || cr)) begin
          cont = 1'b0;
        end else if (eot || nl) begin
          res[n_res] = mk_tok(KIND_RAWBODY, ERR_NONE, 8'h00, 16'(off_q), 16'd0,
                              16'(line_q), 16'(col_q), 1'b0);
          n_res  = n_res + 2'd1;
          mode_d = M_IDLE;
        end else begin
          ts_off_d  = off_q;
          ts_line_d = line_q;
          ts_col_d  = col_q;
          tbl_d     = Pb'(1);
          mode_d    = M_BODY;
          cont      = 1'b0;
        end
      end

      // Start of a new token
      if (cont && mode_d == M_IDLE) begin
        if (eot) begin
          res[n_res] = mk_tok(KIND_EOF, ERR_NONE, 8'h00, 16'(off_q), 16'd0,
                              16'(line_q), 16'(col_q), 1'b1);
          n_res  = n_res + 2'd1;
          mode_d = M_DONE;
        end else if (blank || cr) begin
          mode_d = M_IDLE;
        end else if (nl) begin
          res[n_res] = mk_tok(KIND_NEWLINE, ERR_NONE, 8'h00, 16'(off_q), 16'd0,
                              16'(line_q), 16'(col_q), 1'b0);
          n_res  = n_res + 2'd1;
        end else if (c == "\"" || is_digit(c) || is_word_start(c)) begin
          ts_off_d  = off_q;
          ts_line_d = line_q;
          ts_col_d  = col_q;
          if (c == "\"") begin
            mode_d = M_STRING;
          end else if (is_digit(c)) begin
            mode_d = M_INT;
          end else begin
            flags_d = kw_match('1, 4'd0, c);
            wl_d    = 4'd1;
            mode_d  = M_IDENT;
          end
        end else if (c == "#") begin
          mode_d = M_COMMENT;
        end else begin
          res[n_res] = mk_tok(KIND_ERROR, ERR_BAD_CHAR, c, 16'(off_q), 16'd0,
                              16'(line_q), 16'(col_q), 1'b1);
          n_res  = n_res + 2'd1;
          mode_d = M_DONE;
        end
      end

      // Position counters
      if (!eot && mode_q != M_DONE) begin
        off_d = sat_inc(off_q);
        if (nl) begin
          line_d = sat_inc(line_q);
          col_d  = Pb'(1);
        end else begin
          col_d = sat_inc(col_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      off_q     <= '0;
      line_q    <= Pb'(1);
      col_q     <= Pb'(1);
      ts_off_q  <= '0;
      ts_line_q <= Pb'(1);
      ts_col_q  <= Pb'(1);
      tbl_q     <= '0;
      flags_q   <= '1;
      wl_q      <= '0;
    end else begin
      mode_q    <= mode_d;
      off_q     <= off_d;
      line_q    <= line_d;
      col_q     <= col_d;
      ts_off_q  <= ts_off_d;
      ts_line_q <= ts_line_d;
      ts_col_q  <= ts_col_d;
      tbl_q     <= tbl_d;
      flags_q   <= flags_d;
      wl_q      <= wl_d;
    end
  end

  // Token queue: up to three writes, one read per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoAw'(n_res);
      rd_ptr_q <= rd_ptr_q + FifoAw'(pop);
      cnt_q    <= cnt_q + FifoCw'(n_res) - FifoCw'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (2'(i) < n_res) mem_q[wr_ptr_q + FifoAw'(i)] <= res[i];
    end
  end

  // Output transfer
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tuser_o  = mem_q[rd_ptr_q].kind;
  assign m_axis_tlast_o  = mem_q[rd_ptr_q].last;
  assign m_axis_tdata_o  = {6'b0, mem_q[rd_ptr_q].col, mem_q[rd_ptr_q].line,
                            mem_q[rd_ptr_q].len, mem_q[rd_ptr_q].off,
                            mem_q[rd_ptr_q].ch, mem_q[rd_ptr_q].err};

  `RST_ASSERT(a_queue_fits,
              (FifoCw+1)'(cnt_q) + (FifoCw+1)'(n_res) <=
              (FifoCw+1)'(FifoDepth) + (FifoCw+1)'(pop),
              "token queue overflow")
  `RST_ASSERT(a_done_silent,
              (in_vld_q && mode_q == M_DONE) |-> (n_res == 2'd0),
              "token after end of text")
  `RST_ASSERT(a_last_kind,
              (m_axis_tvalid_o && m_axis_tlast_o) |->
              (m_axis_tuser_o == KIND_EOF || m_axis_tuser_o == KIND_ERROR),
              "last on non-final token")
  `CLK_ASSERT(a_reset_empty,
              !rst_ni |=> (!m_axis_tvalid_o || !$past(rst_ni)),
              "output valid right after reset")

endmodule
